[sv/mls_pkg.sv]
// package for the motion lighting sequencer
// request and response payload types, configuration types, phase codes
// no dependencies
`default_nettype none

package mls_pkg;

   localparam int HourWidth  = 5;
   localparam int TickWidth  = 6;
   localparam int CsrIdxWidth = 2;
   localparam int CsrDataWidth = 6;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_DAY_START = 2'd0,
      CSR_DAY_END   = 2'd1,
      CSR_RAMP      = 2'd2,
      CSR_HOLD      = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_RAMP = 3'd1,
      PH_HOLD = 3'd2,
      PH_OFF1 = 3'd3,
      PH_OFF3 = 3'd4
   } phase_type;

   typedef struct packed {
      logic                 motion_first;
      logic                 motion_second;
      logic                 force_on;
      logic                 force_off;
      logic [HourWidth-1:0] hour_now;
   } req_type;

   typedef struct packed {
      logic lamp_first;
      logic lamp_middle;
      logic lamp_last;
   } rsp_type;

   typedef struct packed {
      logic [HourWidth-1:0] day_start_hour;
      logic [HourWidth-1:0] day_end_hour;
      logic [TickWidth-1:0] ramp_ticks;
      logic [TickWidth-1:0] hold_ticks;
   } cfg_type;

   localparam logic [HourWidth-1:0] DayStartReset = 5'd7;
   localparam logic [HourWidth-1:0] DayEndReset   = 5'd17;
   localparam logic [TickWidth-1:0] RampReset     = 6'd40;
   localparam logic [TickWidth-1:0] HoldReset     = 6'd20;

   // a zero wait setting behaves as one tick
   function automatic logic [TickWidth-1:0] ticks_of(input logic [TickWidth-1:0] setting);
      ticks_of = (setting == '0) ? TickWidth'(1) : setting;
   endfunction

endpackage

`default_nettype wire

[sv/mls_csr.sv]
// configuration registers of the motion lighting sequencer
// depends on mls_pkg
`default_nettype none

module mls_csr
   import mls_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_we,
   input  wire logic [CsrIdxWidth-1:0]  csr_index,
   input  wire logic [CsrDataWidth-1:0] csr_wdata,
   output cfg_type                      cfg
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.day_start_hour <= DayStartReset;
         cfg_ff.day_end_hour   <= DayEndReset;
         cfg_ff.ramp_ticks     <= RampReset;
         cfg_ff.hold_ticks     <= HoldReset;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_DAY_START: cfg_ff.day_start_hour <= csr_wdata[HourWidth-1:0];
            CSR_DAY_END:   cfg_ff.day_end_hour   <= csr_wdata[HourWidth-1:0];
            CSR_RAMP:      cfg_ff.ramp_ticks     <= csr_wdata[TickWidth-1:0];
            CSR_HOLD:      cfg_ff.hold_ticks     <= csr_wdata[TickWidth-1:0];
            default:       cfg_ff <= cfg_ff;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[sv/mls_core.sv]
// sequencer state and the per-tick update of the motion lighting sequencer
// depends on mls_pkg
`default_nettype none

module mls_core
   import mls_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    step,      // consume one tick this cycle
   input  wire req_type req,
   input  wire cfg_type cfg,
   output rsp_type      lamps_next // lamp drives after this tick
);

   logic [2:0]           lamp_ff,  lamp_in;
   logic                 pend_ff,  pend_in;
   phase_type            phase_ff, phase_in;
   logic [TickWidth-1:0] wait_ff,  wait_in;

   logic                 button;
   logic [TickWidth-1:0] wait_dec;
   logic                 is_day;
   logic                 motion;

   always_comb begin
      button   = req.force_on | req.force_off;
      motion   = req.motion_first | req.motion_second;
      wait_dec = wait_ff - TickWidth'(1);
      is_day   = (cfg.day_start_hour <= req.hour_now) && (req.hour_now < cfg.day_end_hour);

      lamp_in  = lamp_ff;
      pend_in  = pend_ff;
      phase_in = phase_ff;
      wait_in  = wait_ff;

      unique case (phase_ff)
         PH_RAMP: begin
            if (!button) wait_in = wait_dec;
            if (button || wait_dec == '0) begin
               lamp_in[1] = 1'b1;
               phase_in   = PH_HOLD;
               wait_in    = ticks_of(cfg.hold_ticks);
            end
         end
         PH_HOLD: begin
            if (motion || button) begin
               phase_in = PH_IDLE;
            end else begin
               wait_in = wait_dec;
               if (wait_dec == '0) begin
                  lamp_in[1] = 1'b0;
                  pend_in    = 1'b0;
                  if (lamp_ff[0]) begin
                     phase_in = PH_OFF1;
                     wait_in  = ticks_of(cfg.ramp_ticks);
                  end else if (lamp_ff[2]) begin
                     phase_in = PH_OFF3;
                     wait_in  = ticks_of(cfg.ramp_ticks);
                  end else begin
                     phase_in = PH_IDLE;
                  end
               end
            end
         end
         PH_OFF1: begin
            if (!button) wait_in = wait_dec;
            if (button || wait_dec == '0) begin
               lamp_in[0] = 1'b0;
               if (lamp_ff[2]) begin
                  phase_in = PH_OFF3;
                  wait_in  = ticks_of(cfg.ramp_ticks);
               end else begin
                  phase_in = PH_IDLE;
               end
            end
         end
         PH_OFF3: begin
            if (!button) wait_in = wait_dec;
            if (button || wait_dec == '0) begin
               lamp_in[2] = 1'b0;
               phase_in   = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
            priority if (req.force_on) begin
               lamp_in = 3'b111;
            end else if (req.force_off || is_day) begin
               lamp_in = 3'b000;
            end else begin
               if (lamp_ff == 3'b111) lamp_in = 3'b000;
               if (req.motion_first) begin
                  lamp_in[0] = 1'b1;
                  lamp_in[2] = 1'b0;
                  pend_in    = 1'b1;
               end
               if (req.motion_second) begin
                  lamp_in[2] = 1'b1;
                  lamp_in[0] = 1'b0;
                  pend_in    = 1'b1;
               end
               if (pend_in && !lamp_in[1]) begin
                  phase_in = PH_RAMP;
                  wait_in  = ticks_of(cfg.ramp_ticks);
               end else if (!motion) begin
                  phase_in = PH_HOLD;
                  wait_in  = ticks_of(cfg.hold_ticks);
               end
            end
         end
      endcase

      lamps_next.lamp_first  = lamp_in[0];
      lamps_next.lamp_middle = lamp_in[1];
      lamps_next.lamp_last   = lamp_in[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lamp_ff  <= '0;
         pend_ff  <= 1'b0;
         phase_ff <= PH_IDLE;
         wait_ff  <= '0;
      end else if (step) begin
         lamp_ff  <= lamp_in;
         pend_ff  <= pend_in;
         phase_ff <= phase_in;
         wait_ff  <= wait_in;
      end
   end

   // every wait phase runs with a nonzero count
   a_wait_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_IDLE |-> wait_ff != '0)
      else $error("wait phase with empty counter");

   // the first-off wait only runs while the first lamp is lit
   a_off1_lit: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_OFF1 |-> lamp_ff[0])
      else $error("first-off wait with first lamp dark");

   // the last-off wait only runs while the last lamp is lit
   a_off3_lit: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_OFF3 |-> lamp_ff[2])
      else $error("last-off wait with last lamp dark");

endmodule

`default_nettype wire

[sv/motion_lighting_sequencer.sv]
// top level of the motion lighting sequencer
// depends on mls_pkg, mls_csr and mls_core
`default_nettype none

// usage
//   req channel: one request per time tick with two motion flags, the on and
//   off buttons and the current hour; valid/ready handshake
//   rsp channel: one response per request with the three lamp drives as
//   they stand after that tick; valid/ready handshake
//   csr port: write enable, register index and data, taken on any edge with
//   csr_we high; write only while no request is in flight
// timing
//   a request lands in the input register, the sequencer state updates as
//   it moves to the response register, whose valid flag drives rsp_valid;
//   one request per cycle sustained while rsp_ready stays high
//   the rate is set by the state update between the two regs
// stall
//   when rsp_ready is low the response register holds, the input register
//   can still take one more request, then req_ready drops
// reset
//   lamps dark, sequencer idle, registers back to 7, 17, 40 and 20

module motion_lighting_sequencer
   import mls_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output      logic                    req_ready,
   input  wire req_type                 req_data,
   output      logic                    rsp_valid,
   input  wire logic                    rsp_ready,
   output rsp_type                      rsp_data,
   input  wire logic                    csr_we,
   input  wire logic [CsrIdxWidth-1:0]  csr_index,
   input  wire logic [CsrDataWidth-1:0] csr_wdata
);

   // input register
   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   // response register
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;

   logic    advance;   // request moves from input to response register
   cfg_type cfg;
   rsp_type lamps_next;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in  = (in_valid_ff && !advance) || (req_valid && req_ready);
      out_valid_in = advance || (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_data_ff <= req_data;
      if (advance) out_data_ff <= lamps_next;
   end

   mls_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   mls_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .req        (in_data_ff),
      .cfg        (cfg),
      .lamps_next (lamps_next)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

`default_nettype wire

[dv/tb_top.sv]
// testbench for the motion lighting sequencer: directed table, then random ticks
// depends on mls_pkg and motion_lighting_sequencer; own lamp predictor inside
`timescale 1ns / 100ps

module tb_top;
   import mls_pkg::*;

   // kinds of row in the directed table
   typedef enum bit {STEP_REQ, STEP_CSR} step_kind_type;

   typedef struct packed {
      step_kind_type kind;
      csr_index_type reg_sel;
      logic [5:0]    reg_val;
      req_type       req;
      bit            known;   // expected lamps typed in below
      rsp_type       want;
   } script_row_type;

   localparam rsp_type Dark   = '0;
   localparam rsp_type AllLit = '1;
   localparam int ScriptLen   = 31;
   localparam int NumPhases   = 7;

   logic                    clock     = 1'b0;
   logic                    reset     = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   req_type                 req_data  = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   rsp_type                 rsp_data;
   logic                    csr_we    = 1'b0;
   logic [CsrIdxWidth-1:0]  csr_index = '0;
   logic [CsrDataWidth-1:0] csr_wdata = '0;

   // shadow of the registers and the sequencer state
   cfg_type             cfg_now       = '{DayStartReset, DayEndReset, RampReset, HoldReset};
   logic [2:0]          lit           = '0;   // bit0 first, bit1 middle, bit2 last
   logic                middle_wanted = 1'b0;
   phase_type           seq_phase     = PH_IDLE;
   logic [TickWidth-1:0] ticks_left   = '0;

   rsp_type lamps_due [$];
   rsp_type oldest;
   int      bad_count  = 0;
   int      burst_left = 0;

   // directed table
   script_row_type script [ScriptLen] = '{
      // day hours after reset: dark
      '{STEP_REQ, CSR_DAY_START, 6'd0, '{1'b0, 1'b0, 1'b0, 1'b0, 5'd12}, 1'b1, Dark},
      // on button, both buttons (on wins), off button
      '{STEP_REQ, CSR_DAY_START, 6'd0, '{1'b0, 1'b0, 1'b1, 1'b0, 5'd12}, 1'b1, AllLit},
      '{STEP_REQ, CSR_DAY_START, 6'd0, '{1'b0, 1'b0, 1'b1, 1'b1, 5'd0}, 1'b1, AllLit},
      '{STEP_REQ, CSR_DAY_START, 6'd0, '{1'b0, 1'b0, 1'b0, 1'b1, 5'd0}, 1'b1, Dark},
      // night with no motion starts the hold wait, on button aborts it
      '{STEP_REQ, CSR_DAY_START, 6'd0, '{1'b0, 1'b0, 1'b0, 1'b0, 5'd23}, 1'b0, Dark},
      '{STEP_REQ, CSR_DAY_START, 6'd0, '{1'b0, 1'b0, 1'b1, 1'b0, 5'd23}, 1'b0, Dark},
      // first end motion, ramp cut short by off button, motion during hold
      '{STEP_REQ, CSR_DAY_START, 6'd0, '{1'b1, 1'b0, 1'b0, 1'b0, 5'd0}, 1'b0, Dark},
      '{STEP_REQ, CSR_DAY_START, 6'd0, '{1'b0, 1'b0, 1'b0, 1'b1, 5'd0}, 1'b0, Dark},
      '{STEP_REQ, CSR_DAY_START, 6'd0, '{1'b0, 1'b1, 1'b0, 1'b0, 5'd0}, 1'b0, Dark},
      // both sensors at the top hour: second end wins
      '{STEP_REQ, CSR_DAY_START, 6'd0, '{1'b1, 1'b1, 1'b0, 1'b0, 5'd31}, 1'b0, Dark},
      // zero wait settings act as one tick
      '{STEP_CSR, CSR_HOLD,      6'd0, '0, 1'b0, Dark},
      '{STEP_CSR, CSR_RAMP,      6'd0, '0, 1'b0, Dark},
      // hold runs out, last end goes out; then the same through the first end
      '{STEP_REQ, CSR_DAY_START, 6'd0, '{1'b0, 1'b0, 1'b0, 1'b0, 5'd17}, 1'b0, Dark},
      '{STEP_REQ, CSR_DAY_START, 6'd0, '{1'b0, 1'b0, 1'b0, 1'b0, 5'd17}, 1'b0, Dark},
      '{STEP_REQ, CSR_DAY_START, 6'd0, '{1'b0, 1'b0, 1'b0, 1'b0, 5'd17}, 1'b0, Dark},
      '{STEP_REQ, CSR_DAY_START, 6'd0, '{1'b1, 1'b0, 1'b0, 1'b0, 5'd20}, 1'b0, Dark},
      '{STEP_REQ, CSR_DAY_START, 6'd0, '{1'b0, 1'b0, 1'b0, 1'b0, 5'd20}, 1'b0, Dark},
      '{STEP_REQ, CSR_DAY_START, 6'd0, '{1'b0, 1'b0, 1'b0, 1'b0, 5'd20}, 1'b0, Dark},
      '{STEP_REQ, CSR_DAY_START, 6'd0, '{1'b0, 1'b0, 1'b0, 1'b0, 5'd20}, 1'b0, Dark},
      // all lit at night gets cleared on the next idle tick
      '{STEP_REQ, CSR_DAY_START, 6'd0, '{1'b0, 1'b0, 1'b1, 1'b0, 5'd3}, 1'b1, AllLit},
      '{STEP_REQ, CSR_DAY_START, 6'd0, '{1'b0, 1'b0, 1'b0, 1'b0, 5'd3}, 1'b0, Dark},
      '{STEP_REQ, CSR_DAY_START, 6'd0, '{1'b0, 1'b0, 1'b0, 1'b1, 5'd5}, 1'b0, Dark},
      // day over every clock hour, longest ramp
      '{STEP_CSR, CSR_DAY_START, 6'd0,  '0, 1'b0, Dark},
      '{STEP_CSR, CSR_DAY_END,   6'd24, '0, 1'b0, Dark},
      '{STEP_CSR, CSR_RAMP,      6'd63, '0, 1'b0, Dark},
      '{STEP_REQ, CSR_DAY_START, 6'd0, '{1'b0, 1'b1, 1'b0, 1'b0, 5'd10}, 1'b1, Dark},
      // hour past the day end is night; long ramp then off wait cut by buttons
      '{STEP_REQ, CSR_DAY_START, 6'd0, '{1'b0, 1'b1, 1'b0, 1'b0, 5'd24}, 1'b0, Dark},
      '{STEP_REQ, CSR_DAY_START, 6'd0, '{1'b1, 1'b0, 1'b0, 1'b0, 5'd24}, 1'b0, Dark},
      '{STEP_REQ, CSR_DAY_START, 6'd0, '{1'b0, 1'b0, 1'b1, 1'b0, 5'd24}, 1'b0, Dark},
      '{STEP_REQ, CSR_DAY_START, 6'd0, '{1'b0, 1'b0, 1'b0, 1'b0, 5'd31}, 1'b0, Dark},
      '{STEP_REQ, CSR_DAY_START, 6'd0, '{1'b0, 1'b0, 1'b0, 1'b1, 5'd31}, 1'b0, Dark}
   };

   motion_lighting_sequencer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic logic is_day(input logic [HourWidth-1:0] hour);
      return cfg_now.day_start_hour <= hour && hour < cfg_now.day_end_hour;
   endfunction

   // a zero setting still waits one tick
   function automatic void start_wait(input phase_type ph, input logic [TickWidth-1:0] setting);
      seq_phase  = ph;
      ticks_left = (setting == '0) ? TickWidth'(1) : setting;
   endfunction

   // one tick of a wait; a button ends it at once
   function automatic logic wait_over(input logic button);
      if (button) begin
         return 1'b1;
      end
      ticks_left = ticks_left - TickWidth'(1);
      return ticks_left == '0;
   endfunction

   function automatic void last_end_or_idle();
      if (lit[2]) begin
         start_wait(PH_OFF3, cfg_now.ramp_ticks);
      end else begin
         seq_phase = PH_IDLE;
      end
   endfunction

   // advance the shadow sequencer by one tick, return the lamps after it
   function automatic rsp_type step_lamps(input req_type r);
      logic    button;
      rsp_type lamps;
      button = r.force_on | r.force_off;
      case (seq_phase)
         PH_RAMP: begin
            if (wait_over(button)) begin
               lit[1] = 1'b1;
               start_wait(PH_HOLD, cfg_now.hold_ticks);
            end
         end
         PH_HOLD: begin
            // motion or a button drops back to idle without touching lamps
            if (r.motion_first || r.motion_second || button) begin
               seq_phase = PH_IDLE;
            end else if (wait_over(1'b0)) begin
               lit[1]        = 1'b0;
               middle_wanted = 1'b0;
               if (lit[0]) begin
                  start_wait(PH_OFF1, cfg_now.ramp_ticks);
               end else begin
                  last_end_or_idle();
               end
            end
         end
         PH_OFF1: begin
            if (wait_over(button)) begin
               lit[0] = 1'b0;
               last_end_or_idle();
            end
         end
         PH_OFF3: begin
            if (wait_over(button)) begin
               lit[2]    = 1'b0;
               seq_phase = PH_IDLE;
            end
         end
         default: begin
            seq_phase = PH_IDLE;
            if (r.force_on) begin
               lit = 3'b111;
            end else if (r.force_off || is_day(r.hour_now)) begin
               lit = 3'b000;
            end else begin
               if (lit == 3'b111) begin
                  lit = 3'b000;
               end
               if (r.motion_first) begin
                  lit[0]        = 1'b1;
                  lit[2]        = 1'b0;
                  middle_wanted = 1'b1;
               end
               // second end wins when both sensors fire
               if (r.motion_second) begin
                  lit[2]        = 1'b1;
                  lit[0]        = 1'b0;
                  middle_wanted = 1'b1;
               end
               if (middle_wanted && !lit[1]) begin
                  start_wait(PH_RAMP, cfg_now.ramp_ticks);
               end else if (!r.motion_first && !r.motion_second) begin
                  start_wait(PH_HOLD, cfg_now.hold_ticks);
               end
            end
         end
      endcase
      lamps.lamp_first  = lit[0];
      lamps.lamp_middle = lit[1];
      lamps.lamp_last   = lit[2];
      return lamps;
   endfunction

   // ---------------------------------------------------------------- driving

   // offer one request, hold it until taken, then maybe pause between bursts
   task automatic offer(input req_type r, input bit known, input rsp_type want);
      rsp_type guess;
      int      gap;
      if (csr_we) begin
         csr_we <= 1'b0;
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      guess = step_lamps(r);
      lamps_due.push_back(known ? want : guess);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   // stop offering and wait until every response is back
   task automatic settle();
      req_valid <= 1'b0;
      while (lamps_due.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // register write; caller lowers the enable with the next request
   task automatic write_reg(input csr_index_type sel, input logic [5:0] val);
      csr_we    <= 1'b1;
      csr_index <= sel;
      csr_wdata <= val;
      @(posedge clock);
      case (sel)
         CSR_DAY_START: cfg_now.day_start_hour = val[HourWidth-1:0];
         CSR_DAY_END:   cfg_now.day_end_hour   = val[HourWidth-1:0];
         CSR_RAMP:      cfg_now.ramp_ticks     = val;
         default:       cfg_now.hold_ticks     = val;
      endcase
   endtask

   function automatic logic [HourWidth-1:0] pick_hour(input logic night);
      logic [HourWidth-1:0] h;
      h = HourWidth'($urandom_range(0, 31));
      for (int i = 0; i < 64 && is_day(h) == night; i++) begin
         h = HourWidth'($urandom_range(0, 31));
      end
      return h;
   endfunction

   // ---------------------------------------------------------------- stimulus

   initial begin
      req_type    r;
      int         motion_pct;
      int         button_pct;
      int         night_pct;
      int         seg_left;
      int         seg_kind;
      int         items;
      logic [5:0] ds;
      logic [5:0] de;
      motion_pct = 0;
      button_pct = 0;
      night_pct  = 0;
      seg_left   = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (script[i]) begin
         if (script[i].kind == STEP_CSR) begin
            settle();
            write_reg(script[i].reg_sel, script[i].reg_val);
         end else begin
            offer(script[i].req, script[i].known, script[i].want);
         end
      end

      // random ticks, one register setting per phase, extremes first
      for (int p = 0; p < NumPhases; p++) begin
         settle();
         case (p)
            0: begin
               write_reg(CSR_DAY_START, 6'd7);
               write_reg(CSR_DAY_END,   6'd17);
               write_reg(CSR_RAMP,      6'd1);
               write_reg(CSR_HOLD,      6'd1);
            end
            1: begin
               // empty day window: always night
               write_reg(CSR_DAY_START, 6'd0);
               write_reg(CSR_DAY_END,   6'd0);
               write_reg(CSR_RAMP,      6'd2);
               write_reg(CSR_HOLD,      6'd3);
            end
            2: begin
               write_reg(CSR_DAY_START, 6'd23);
               write_reg(CSR_DAY_END,   6'd24);
               write_reg(CSR_RAMP,      6'd63);
               write_reg(CSR_HOLD,      6'd63);
            end
            3: begin
               write_reg(CSR_DAY_START, 6'd31);
               write_reg(CSR_DAY_END,   6'd0);
               write_reg(CSR_RAMP,      6'd0);
               write_reg(CSR_HOLD,      6'd0);
            end
            4: begin
               write_reg(CSR_DAY_START, 6'd0);
               write_reg(CSR_DAY_END,   6'd24);
               write_reg(CSR_RAMP,      6'd5);
               write_reg(CSR_HOLD,      6'd2);
            end
            default: begin
               ds = 6'($urandom_range(0, 23));
               de = 6'($urandom_range(ds, 24));
               write_reg(CSR_DAY_START, ds);
               write_reg(CSR_DAY_END,   de);
               write_reg(CSR_RAMP,      6'($urandom_range(1, 10)));
               write_reg(CSR_HOLD,      6'($urandom_range(1, 10)));
            end
         endcase
         // long waits need long quiet runs to reach the switch-off phases
         items = (p == 2) ? 200 : 85;
         repeat (items) begin
            if (seg_left == 0) begin
               seg_kind = $urandom_range(0, 9);
               if (seg_kind < 4) begin
                  // quiet night: waits run to the end
                  motion_pct = 0;
                  button_pct = 0;
                  night_pct  = 90;
                  seg_left   = $urandom_range(10, 150);
               end else if (seg_kind < 8) begin
                  motion_pct = 20;
                  button_pct = 3;
                  night_pct  = 85;
                  seg_left   = $urandom_range(5, 30);
               end else begin
                  // noise: buttons and day hours everywhere
                  motion_pct = 50;
                  button_pct = 25;
                  night_pct  = 50;
                  seg_left   = $urandom_range(1, 10);
               end
            end
            seg_left--;
            r.motion_first  = $urandom_range(0, 99) < motion_pct;
            r.motion_second = $urandom_range(0, 99) < motion_pct;
            r.force_on      = $urandom_range(0, 99) < button_pct;
            r.force_off     = $urandom_range(0, 99) < button_pct;
            r.hour_now      = pick_hour($urandom_range(0, 99) < night_pct);
            offer(r, 1'b0, Dark);
         end
      end

      settle();
      repeat (8) @(posedge clock);
      if (bad_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // ---------------------------------------------------------------- receiver

   // starts with a long hold-off so the block fills and drops req_ready
   initial begin
      int mode;
      int len;
      @(posedge clock);
      while (reset) begin
         @(posedge clock);
      end
      repeat (60) @(posedge clock);
      forever begin
         mode = $urandom_range(0, 15);
         len  = $urandom_range(1, 40);
         if (mode < 6) begin
            rsp_ready <= 1'b1;
            repeat (len) @(posedge clock);
         end else if (mode < 14) begin
            repeat (len) begin
               rsp_ready <= ($urandom_range(0, 99) < 60);
               @(posedge clock);
            end
         end else begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(30, 80)) @(posedge clock);
         end
      end
   end

   // ---------------------------------------------------------------- checking

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (lamps_due.size() == 0) begin
            bad_count++;
            if (bad_count <= 10) begin
               $display("%0t: response with no request pending: lamps %b %b %b", $realtime,
                        rsp_data.lamp_first, rsp_data.lamp_middle, rsp_data.lamp_last);
            end
         end else begin
            oldest = lamps_due.pop_front();
            if (rsp_data.lamp_first !== oldest.lamp_first ||
                rsp_data.lamp_middle !== oldest.lamp_middle ||
                rsp_data.lamp_last !== oldest.lamp_last) begin
               bad_count++;
               if (bad_count <= 10) begin
                  $display("%0t: lamps first/middle/last expected %b %b %b, got %b %b %b",
                           $realtime, oldest.lamp_first, oldest.lamp_middle,
                           oldest.lamp_last, rsp_data.lamp_first, rsp_data.lamp_middle,
                           rsp_data.lamp_last);
               end
            end
         end
      end
   end

   // run limit
   initial begin
      #10_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

[filelist.f]
sv/mls_pkg.sv
sv/mls_csr.sv
sv/mls_core.sv
sv/motion_lighting_sequencer.sv
dv/tb_top.sv
